// ===== src/qat_pkg.sv =====
`timescale 1ns / 1ps

package qat_pkg;

    // Default sizing
    localparam int MAX_ARGS_DEF = 64;
    localparam int LINE_MAX_DEF = 4096;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;

    // Configuration register indexes
    localparam logic [2:0] REG_SEP_A   = 3'd0;
    localparam logic [2:0] REG_SEP_B   = 3'd1;
    localparam logic [2:0] REG_SEP_C   = 3'd2;
    localparam logic [2:0] REG_SEP_D   = 3'd3;
    localparam logic [2:0] REG_SEP_CNT = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_LINE = 2'd2;

    // Line status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_OPEN_DQ  = 3'd2;
    localparam logic [2:0] ST_OPEN_SQ  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic        last;
        logic [1:0]  result_kind;
        logic [6:0]  arg_count;
        logic [12:0] error_column;
        logic [2:0]  line_status;
        logic [5:0]  arg_num;
        logic [7:0]  out_byte;
    } result_t;

endpackage

// ===== src/quoted_argument_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Results are written to the result queue and presented on m_* from its head.
// One byte is accepted per cycle while s_tready is high; a byte that yields two
// results (backslash plus byte, argument end plus line end) uses the single result port twice.
// s_tready is held high while the 4-entry result queue has room for two results.
// Reset (aresetn low, synchronous): line state and queue cleared, separators back to
// space, tab, newline, space with count 3.
module quoted_argument_tokenizer_unit #(
    parameter int MAX_ARGS = qat_pkg::MAX_ARGS_DEF,
    parameter int LINE_MAX = qat_pkg::LINE_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data,

    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_byte

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [7:0] out_byte, [13:8] arg_num,
                                     // [16:14] line_status, [29:17] error_column,
                                     // [36:30] arg_count, [39:37] zero
    output logic [1:0]  m_tuser,     // [1:0] result_kind
    output logic        m_tlast      // last result of one input transaction
);

    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int CW = $clog2(LINE_MAX + 1);

    typedef enum logic [1:0] {
        QM_OUTSIDE = 2'd0,
        QM_DOUBLE  = 2'd1,
        QM_SINGLE  = 2'd2
    } quote_mode_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] sep_a_reg, sep_b_reg, sep_c_reg, sep_d_reg;
    logic [2:0] sep_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_a_reg     <= 8'd32;
            sep_b_reg     <= 8'd9;
            sep_c_reg     <= 8'd10;
            sep_d_reg     <= 8'd32;
            sep_count_reg <= 3'd3;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                qat_pkg::REG_SEP_A:   sep_a_reg     <= cfg_wr_data;
                qat_pkg::REG_SEP_B:   sep_b_reg     <= cfg_wr_data;
                qat_pkg::REG_SEP_C:   sep_c_reg     <= cfg_wr_data;
                qat_pkg::REG_SEP_D:   sep_d_reg     <= cfg_wr_data;
                qat_pkg::REG_SEP_CNT: sep_count_reg <= cfg_wr_data[2:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    quote_mode_t   qmode_reg, qmode_next;
    logic          composing_reg, composing_next;
    logic          pend_bsl_reg, pend_bsl_next;
    logic [AW-1:0] arg_cnt_reg, arg_cnt_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] quote_col_reg, quote_col_next;
    logic          ovf_reg, ovf_next;

    // results produced by the current byte
    qat_pkg::result_t res0, res1;
    logic [1:0]       res_n;

    logic             in_xfer;
    logic [7:0]       in_byte;
    logic             is_sep;
    logic [2:0]       sep_cnt_eff;
    logic [2:0]       line_status;

    assign in_xfer = s_tvalid && s_tready;
    assign in_byte = s_tdata;

    // separator match against the active registers, count above four acts as four
    always_comb begin
        sep_cnt_eff = (sep_count_reg > 3'd4) ? 3'd4 : sep_count_reg;
        is_sep = (in_byte == qat_pkg::CH_NUL)
              || (sep_cnt_eff >= 3'd1 && in_byte == sep_a_reg)
              || (sep_cnt_eff >= 3'd2 && in_byte == sep_b_reg)
              || (sep_cnt_eff >= 3'd3 && in_byte == sep_c_reg)
              || (sep_cnt_eff >= 3'd4 && in_byte == sep_d_reg);
    end

    function automatic qat_pkg::result_t mk_data(input logic [7:0] b,
                                                 input logic [AW-1:0] ac);
        qat_pkg::result_t r;
        r              = '0;
        r.result_kind  = qat_pkg::KIND_DATA;
        r.out_byte     = b;
        r.arg_num      = (ac != '0) ? 6'(ac - AW'(1)) : 6'd0;
        return r;
    endfunction

    function automatic qat_pkg::result_t mk_end(input logic [AW-1:0] ac);
        qat_pkg::result_t r;
        r              = '0;
        r.result_kind  = qat_pkg::KIND_END;
        r.arg_num      = (ac != '0) ? 6'(ac - AW'(1)) : 6'd0;
        return r;
    endfunction

    function automatic qat_pkg::result_t mk_line(input logic [2:0] st,
                                                 input logic [CW-1:0] qc,
                                                 input logic [AW-1:0] ac);
        qat_pkg::result_t r;
        r              = '0;
        r.result_kind  = qat_pkg::KIND_LINE;
        r.line_status  = st;
        r.error_column = (st == qat_pkg::ST_OPEN_DQ || st == qat_pkg::ST_OPEN_SQ)
                         ? 13'(qc) : 13'd0;
        r.arg_count    = 7'(ac);
        return r;
    endfunction

    // Per-byte decision. Column and argument counters saturate and raise the
    // overflow flag; a line end reports overflow above open quotes.
    always_comb begin
        qmode_next     = qmode_reg;
        composing_next = composing_reg;
        pend_bsl_next  = pend_bsl_reg;
        arg_cnt_next   = arg_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        quote_col_next = quote_col_reg;
        ovf_next       = ovf_reg;
        res0           = '0;
        res1           = '0;
        res_n          = 2'd0;
        line_status    = qat_pkg::ST_OK;

        if (in_byte != qat_pkg::CH_NUL) begin
            if (col_cnt_reg < CW'(LINE_MAX)) begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        // status of a line end, if this byte ends the line
        if (ovf_next) begin
            line_status = qat_pkg::ST_OVERFLOW;
        end else if (qmode_reg == QM_DOUBLE) begin
            line_status = qat_pkg::ST_OPEN_DQ;
        end else if (qmode_reg == QM_SINGLE) begin
            line_status = qat_pkg::ST_OPEN_SQ;
        end else if (col_cnt_next == '0) begin
            line_status = qat_pkg::ST_EMPTY;
        end

        unique case (qmode_reg)
            QM_DOUBLE: begin
                if (in_byte == qat_pkg::CH_NUL) begin
                    res0  = mk_line(line_status, quote_col_reg, arg_cnt_reg);
                    res_n = 2'd1;
                end else if (pend_bsl_reg) begin
                    pend_bsl_next = 1'b0;
                    if (in_byte != qat_pkg::CH_DQ) begin
                        res0  = mk_data(qat_pkg::CH_BSL, arg_cnt_reg);
                        res1  = mk_data(in_byte, arg_cnt_reg);
                        res_n = 2'd2;
                    end else begin
                        res0  = mk_data(in_byte, arg_cnt_reg);
                        res_n = 2'd1;
                    end
                end else if (in_byte == qat_pkg::CH_BSL) begin
                    pend_bsl_next = 1'b1;
                end else if (in_byte == qat_pkg::CH_DQ) begin
                    qmode_next = QM_OUTSIDE;
                end else begin
                    res0  = mk_data(in_byte, arg_cnt_reg);
                    res_n = 2'd1;
                end
            end
            QM_SINGLE: begin
                if (in_byte == qat_pkg::CH_NUL) begin
                    res0  = mk_line(line_status, quote_col_reg, arg_cnt_reg);
                    res_n = 2'd1;
                end else if (in_byte == qat_pkg::CH_SQ) begin
                    qmode_next = QM_OUTSIDE;
                end else begin
                    res0  = mk_data(in_byte, arg_cnt_reg);
                    res_n = 2'd1;
                end
            end
            default: begin
                if (pend_bsl_reg) begin
                    pend_bsl_next = 1'b0;
                    if (in_byte == qat_pkg::CH_NUL) begin
                        res0  = mk_end(arg_cnt_reg);
                        res1  = mk_line(line_status, quote_col_reg, arg_cnt_reg);
                        res_n = 2'd2;
                    end else if (in_byte == qat_pkg::CH_DQ || in_byte == qat_pkg::CH_SQ
                                 || is_sep) begin
                        res0  = mk_data(in_byte, arg_cnt_reg);
                        res_n = 2'd1;
                    end else begin
                        res0  = mk_data(qat_pkg::CH_BSL, arg_cnt_reg);
                        res1  = mk_data(in_byte, arg_cnt_reg);
                        res_n = 2'd2;
                    end
                end else if (is_sep) begin
                    if (composing_reg) begin
                        composing_next = 1'b0;
                        res0 = mk_end(arg_cnt_reg);
                        if (in_byte == qat_pkg::CH_NUL) begin
                            res1  = mk_line(line_status, quote_col_reg, arg_cnt_reg);
                            res_n = 2'd2;
                        end else begin
                            res_n = 2'd1;
                        end
                    end else if (in_byte == qat_pkg::CH_NUL) begin
                        res0  = mk_line(line_status, quote_col_reg, arg_cnt_reg);
                        res_n = 2'd1;
                    end
                end else begin
                    if (!composing_reg) begin
                        composing_next = 1'b1;
                        if (arg_cnt_reg < AW'(MAX_ARGS)) begin
                            arg_cnt_next = arg_cnt_reg + AW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (in_byte == qat_pkg::CH_BSL) begin
                        pend_bsl_next = 1'b1;
                    end else if (in_byte == qat_pkg::CH_DQ) begin
                        qmode_next     = QM_DOUBLE;
                        quote_col_next = col_cnt_next;
                    end else if (in_byte == qat_pkg::CH_SQ) begin
                        qmode_next     = QM_SINGLE;
                        quote_col_next = col_cnt_next;
                    end else begin
                        res0  = mk_data(in_byte, arg_cnt_next);
                        res_n = 2'd1;
                    end
                end
            end
        endcase

        // line end returns all line state to reset
        if (in_byte == qat_pkg::CH_NUL) begin
            qmode_next     = QM_OUTSIDE;
            composing_next = 1'b0;
            pend_bsl_next  = 1'b0;
            arg_cnt_next   = '0;
            col_cnt_next   = '0;
            quote_col_next = '0;
            ovf_next       = 1'b0;
        end

        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end else if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qmode_reg     <= QM_OUTSIDE;
            composing_reg <= 1'b0;
            pend_bsl_reg  <= 1'b0;
            arg_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            quote_col_reg <= '0;
            ovf_reg       <= 1'b0;
        end else if (in_xfer) begin
            qmode_reg     <= qmode_next;
            composing_reg <= composing_next;
            pend_bsl_reg  <= pend_bsl_next;
            arg_cnt_reg   <= arg_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            quote_col_reg <= quote_col_next;
            ovf_reg       <= ovf_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: 4 entries, up to two pushed and one popped per cycle
    // ------------------------------------------------------------------
    qat_pkg::result_t q_mem [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       q_cnt_reg, q_cnt_next;
    logic [1:0]       push_n;
    logic             pop;

    // no transaction is taken while reset is held
    assign s_tready = aresetn && (q_cnt_reg <= 3'd2);
    assign m_tvalid = (q_cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign push_n   = in_xfer ? res_n : 2'd0;

    always_comb begin
        q_cnt_next = q_cnt_reg + 3'(push_n) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    qat_pkg::result_t head;
    assign head = q_mem[rd_ptr_reg];

    assign m_tdata = {3'b000, head.arg_count, head.error_column, head.line_status,
                      head.arg_num, head.out_byte};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ARGS      = qat_pkg::MAX_ARGS_DEF;
    localparam int LINE_MAX      = qat_pkg::LINE_MAX_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;     // keep the log short on a broken build
    localparam int MAX_GAP       = 16;

    typedef enum logic [1:0] {QM_NONE, QM_DOUBLE, QM_SINGLE} quote_mode_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_addr    = '0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;     // [7:0] char_byte
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;              // [7:0] out_byte, [13:8] arg_num,
                                       // [16:14] line_status, [29:17] error_column,
                                       // [36:30] arg_count, [39:37] zero
    logic [1:0]  m_tuser;              // [1:0] result_kind
    logic        m_tlast;

    quoted_argument_tokenizer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: separator registers and line state
    // ------------------------------------------------------------------
    logic [7:0]  sep_chars [4];
    logic [2:0]  sep_active;
    quote_mode_t qmode;
    logic        composing;
    logic        bsl_pending;
    logic        line_ovf;
    logic [6:0]  arg_cnt;
    logic [12:0] col_cnt;
    logic [12:0] quote_col;

    qat_pkg::result_t step_res[$];      // results of the byte being tokenized
    qat_pkg::result_t token_q[$];       // expected results, oldest first

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit failed          = 1'b0;
    int reports         = 0;

    function automatic void clear_line();
        qmode       = QM_NONE;
        composing   = 1'b0;
        bsl_pending = 1'b0;
        line_ovf    = 1'b0;
        arg_cnt     = '0;
        col_cnt     = '0;
        quote_col   = '0;
    endfunction

    // NUL always splits; a count above four acts as four
    function automatic bit is_separator(input logic [7:0] b);
        int n;
        n = (sep_active > 3'd4) ? 4 : int'(sep_active);
        if (b == qat_pkg::CH_NUL)
            return 1'b1;
        for (int i = 0; i < n; i++)
            if (sep_chars[2'(i)] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [5:0] cur_arg();
        logic [6:0] t;
        t = (arg_cnt == 7'd0) ? 7'd0 : arg_cnt - 7'd1;
        return t[5:0];
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [5:0] idx, input logic [2:0] st,
                                       input logic [12:0] col, input logic [6:0] cnt);
        qat_pkg::result_t r;
        if (step_res.size() >= 2)
            return;
        r              = '0;
        r.result_kind  = kind;
        r.out_byte     = b;
        r.arg_num      = idx;
        r.line_status  = st;
        r.error_column = col;
        r.arg_count    = cnt;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        add_result(qat_pkg::KIND_DATA, b, cur_arg(), qat_pkg::ST_OK, '0, '0);
    endfunction

    function automatic void emit_end();
        add_result(qat_pkg::KIND_END, '0, cur_arg(), qat_pkg::ST_OK, '0, '0);
        composing = 1'b0;
    endfunction

    // overflow outranks everything; a bare terminator is an empty line
    function automatic void emit_line(input logic [2:0] status);
        logic [2:0]  st;
        logic [12:0] col;
        st  = status;
        col = '0;
        if (line_ovf)
            st = qat_pkg::ST_OVERFLOW;
        else if (st == qat_pkg::ST_OK && col_cnt == 13'd0)
            st = qat_pkg::ST_EMPTY;
        if (st == qat_pkg::ST_OPEN_DQ || st == qat_pkg::ST_OPEN_SQ)
            col = quote_col;
        add_result(qat_pkg::KIND_LINE, '0, '0, st, col, arg_cnt);
        clear_line();
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b);
        qat_pkg::result_t r;
        if (b != qat_pkg::CH_NUL) begin
            if (int'(col_cnt) < LINE_MAX)
                col_cnt++;
            else
                line_ovf = 1'b1;
        end
        unique case (qmode)
            QM_DOUBLE: begin
                if (b == qat_pkg::CH_NUL) begin
                    // trailing backslash lands here too
                    emit_line(qat_pkg::ST_OPEN_DQ);
                end else if (bsl_pending) begin
                    bsl_pending = 1'b0;
                    if (b != qat_pkg::CH_DQ)
                        emit_data(qat_pkg::CH_BSL);
                    emit_data(b);
                end else if (b == qat_pkg::CH_BSL) begin
                    bsl_pending = 1'b1;
                end else if (b == qat_pkg::CH_DQ) begin
                    qmode = QM_NONE;
                end else begin
                    emit_data(b);
                end
            end
            QM_SINGLE: begin
                if (b == qat_pkg::CH_NUL)
                    emit_line(qat_pkg::ST_OPEN_SQ);
                else if (b == qat_pkg::CH_SQ)
                    qmode = QM_NONE;
                else
                    emit_data(b);
            end
            default: begin
                if (bsl_pending) begin
                    bsl_pending = 1'b0;
                    if (b == qat_pkg::CH_NUL) begin
                        emit_end();
                        emit_line(qat_pkg::ST_OK);
                    end else if (b == qat_pkg::CH_DQ || b == qat_pkg::CH_SQ
                                 || is_separator(b)) begin
                        emit_data(b);
                    end else begin
                        emit_data(qat_pkg::CH_BSL);
                        emit_data(b);
                    end
                end else if (is_separator(b)) begin
                    // separator test wins over quote and backslash meaning
                    if (composing)
                        emit_end();
                    if (b == qat_pkg::CH_NUL)
                        emit_line(qat_pkg::ST_OK);
                end else begin
                    if (!composing) begin
                        composing = 1'b1;
                        if (int'(arg_cnt) < MAX_ARGS)
                            arg_cnt++;
                        else
                            line_ovf = 1'b1;
                    end
                    if (b == qat_pkg::CH_BSL) begin
                        bsl_pending = 1'b1;
                    end else if (b == qat_pkg::CH_DQ) begin
                        qmode     = QM_DOUBLE;
                        quote_col = col_cnt;
                    end else if (b == qat_pkg::CH_SQ) begin
                        qmode     = QM_SINGLE;
                        quote_col = col_cnt;
                    end else begin
                        emit_data(b);
                    end
                end
            end
        endcase
        if (step_res.size() > 0) begin
            r      = step_res.pop_back();
            r.last = 1'b1;
            step_res.insert(step_res.size(), r);
        end
        while (step_res.size() > 0)
            token_q.insert(token_q.size(), step_res.pop_front());
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver back-pressure, monitor
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            failed = 1'b1;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            reports++;
        end
    endtask

    task automatic check_result();
        qat_pkg::result_t want;
        if (token_q.size() == 0) begin
            failed = 1'b1;
            if (reports < MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
            reports++;
        end else begin
            want = token_q.pop_front();
            check_field("result_kind",  int'(want.result_kind),  int'(m_tuser));
            check_field("out_byte",     int'(want.out_byte),     int'(m_tdata[7:0]));
            check_field("arg_num",      int'(want.arg_num),      int'(m_tdata[13:8]));
            check_field("line_status",  int'(want.line_status),  int'(m_tdata[16:14]));
            check_field("error_column", int'(want.error_column), int'(m_tdata[29:17]));
            check_field("arg_count",    int'(want.arg_count),    int'(m_tdata[36:30]));
            check_field("last",         int'(want.last),         int'(m_tlast));
        end
    endtask

    // Both channels are sampled here, before this edge's updates land.
    // Results are checked first, then the accepted byte is tokenized.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // One byte transaction, with a random idle gap in front of it.
    // tvalid is only lowered when a gap actually follows.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && int'($urandom_range(0, 99)) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Text bytes followed by the NUL terminator
    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
        send_byte(qat_pkg::CH_NUL);
    endtask

    // Wait for every expected result, then let a byte with no result settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (token_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx < qat_pkg::REG_SEP_CNT)
            sep_chars[idx[1:0]] = val;
        else if (idx == qat_pkg::REG_SEP_CNT)
            sep_active = val[2:0];
    endtask

    task automatic set_separators(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c, input logic [7:0] d,
                                  input logic [2:0] cnt);
        write_reg(qat_pkg::REG_SEP_A, a);
        write_reg(qat_pkg::REG_SEP_B, b);
        write_reg(qat_pkg::REG_SEP_C, c);
        write_reg(qat_pkg::REG_SEP_D, d);
        write_reg(qat_pkg::REG_SEP_CNT, {5'd0, cnt});
    endtask

    // Half the time shell-like punctuation, otherwise any nonzero byte
    function automatic logic [7:0] pick_sep();
        string common;
        logic [7:0] v;
        common = " ,;:|";
        if ($urandom_range(0, 1) != 0)
            v = common[int'($urandom_range(0, 4))];
        else
            v = 8'($urandom_range(1, 255));
        return v;
    endfunction

    // Weighted toward the bytes that steer the tokenizer
    function automatic logic [7:0] pick_byte();
        int r;
        logic [7:0] v;
        r = int'($urandom_range(0, 99));
        if (r < 40)
            v = 8'($urandom_range(97, 122));
        else if (r < 55)
            v = sep_chars[2'($urandom_range(0, 3))];
        else if (r < 65)
            v = qat_pkg::CH_DQ;
        else if (r < 73)
            v = qat_pkg::CH_SQ;
        else if (r < 83)
            v = qat_pkg::CH_BSL;
        else
            v = 8'($urandom_range(1, 255));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset separators: empty line, separator-only line, both quote kinds,
    // escapes inside and outside quotes, trailing backslashes, open quotes
    task automatic test_directed_quoting();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_line("");
        send_line(" \t\n");
        send_line("x\"q\\\"r\"\t'p\\' \\ \\z\\\"\\'\"\\a\"\\");
        send_line("\"a\\");
        send_line("b'c");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(qat_pkg::CH_NUL);
        drain_results();
    endtask

    // Quote and backslash as separators, byte extremes as separators,
    // then a count above four and a count of zero
    task automatic test_quote_separators();
        set_separators(qat_pkg::CH_DQ, qat_pkg::CH_BSL, 8'hFF, 8'h01, 3'd4);
        send_line("a\"b\\c");
        send_byte(8'hFF);
        send_byte("d");
        send_byte(8'h01);
        send_line("'e\"f");
        drain_results();
        write_reg(qat_pkg::REG_SEP_CNT, 8'd7);
        send_line("p\"q\\r");
        drain_results();
        write_reg(qat_pkg::REG_SEP_CNT, 8'd0);
        send_line("a b\tc");
        drain_results();
    endtask

    // Exactly MAX_ARGS arguments, then too many with an open quote behind
    task automatic test_arg_limit();
        set_separators(8'd32, 8'd9, 8'd10, 8'd32, 3'd3);
        for (int i = 0; i < MAX_ARGS; i++) begin
            send_byte(8'($urandom_range(97, 122)));
            send_byte(" ");
        end
        send_byte(qat_pkg::CH_NUL);
        for (int i = 0; i < MAX_ARGS + 2; i++) begin
            send_byte(8'($urandom_range(97, 122)));
            send_byte("\t");
        end
        send_line("\"x");
        drain_results();
    endtask

    // Random lines under one idling setting; separators either back at
    // their reset values or drawn at random
    task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                     input bit random_seps, input int n_bytes);
        int sent;
        int len;
        bit noise;
        if (random_seps)
            set_separators(pick_sep(), pick_sep(), pick_sep(), pick_sep(),
                           3'($urandom_range(0, 4)));
        else
            set_separators(8'd32, 8'd9, 8'd10, 8'd32, 3'd3);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < n_bytes) begin
            len   = int'($urandom_range(0, 16));
            noise = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                // noise lines may hold NULs and so split into short lines
                if (noise)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(pick_byte());
            end
            send_byte(qat_pkg::CH_NUL);
            sent += len + 1;
        end
        drain_results();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        sep_chars[0] = 8'd32;
        sep_chars[1] = 8'd9;
        sep_chars[2] = 8'd10;
        sep_chars[3] = 8'd32;
        sep_active   = 3'd3;
        clear_line();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_quoting();
        test_quote_separators();
        test_arg_limit();
        test_random_lines(0, 0, 1'b0, 50);
        test_random_lines(57, 0, 1'b1, 50);
        test_random_lines(0, 57, 1'b1, 50);
        test_random_lines(20, 20, 1'b1, 50);

        if (!failed && token_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #200_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
